// ===== rtl/core/isfp_pkg.sv =====
// ----------------------------------------------------------------------------
// isfp_pkg
// Shared types and constants of the inertial sensor serial frame parser.
// ----------------------------------------------------------------------------
package isfp_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h55;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO  = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] TYPE_MAG   = 8'h54;
   localparam logic [7:0] TYPE_QUAT  = 8'h59;

   localparam int AXES = 3;

   typedef enum logic [1:0] {
      REG_SIGN_MASK    = 2'd0,
      REG_ROLL_OFFSET  = 2'd1,
      REG_PITCH_OFFSET = 2'd2,
      REG_YAW_OFFSET   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_SUM = 2'd1,
      ST_UNKNOWN = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      KIND_ACCEL = 3'd0,
      KIND_GYRO  = 3'd1,
      KIND_ANGLE = 3'd2,
      KIND_MAG   = 3'd3,
      KIND_QUAT  = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [8:0] sign_mask;
   } decode_ctrl_type;

endpackage

// ===== rtl/core/isfp_decode.sv =====
// ----------------------------------------------------------------------------
// isfp_decode
// Per-axis sign correction; angles get offset removal and 17-bit saturation.
// ----------------------------------------------------------------------------
module isfp_decode (
   input  isfp_pkg::decode_ctrl_type ctrl,
   input  logic signed [15:0]        word_a,
   input  logic signed [15:0]        word_b,
   input  logic signed [15:0]        word_c,
   input  logic signed [15:0]        roll_offset,
   input  logic signed [15:0]        pitch_offset,
   input  logic signed [15:0]        yaw_offset,
   output logic signed [16:0]        value_a,
   output logic signed [16:0]        value_b,
   output logic signed [16:0]        value_c
);
   import isfp_pkg::*;

   localparam logic signed [17:0] SAT_HI = 18'sd65535;
   localparam logic signed [17:0] SAT_LO = -18'sd65536;

   logic [15:0]        raw   [AXES];
   logic [15:0]        offs  [AXES];
   logic               neg   [AXES];
   logic [16:0]        raw17 [AXES];
   logic [16:0]        sgn17 [AXES];
   logic signed [17:0] diff  [AXES];
   logic signed [16:0] value [AXES];

   assign raw[0]  = word_a;
   assign raw[1]  = word_b;
   assign raw[2]  = word_c;
   assign offs[0] = roll_offset;
   assign offs[1] = pitch_offset;
   assign offs[2] = yaw_offset;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         case (ctrl.kind)
            KIND_ACCEL: neg[i] = ctrl.sign_mask[i];
            KIND_GYRO:  neg[i] = ctrl.sign_mask[AXES + i];
            KIND_ANGLE: neg[i] = ctrl.sign_mask[2 * AXES + i];
            default:    neg[i] = 1'b0;
         endcase
         raw17[i] = {raw[i][15], raw[i]};
         sgn17[i] = neg[i] ? (17'd0 - raw17[i]) : raw17[i];
         diff[i]  = {sgn17[i][16], sgn17[i]} - {{2{offs[i][15]}}, offs[i]};
         if (ctrl.kind != KIND_ANGLE) begin
            value[i] = sgn17[i];
         end else if (diff[i] > SAT_HI) begin
            value[i] = SAT_HI[16:0];
         end else if (diff[i] < SAT_LO) begin
            value[i] = SAT_LO[16:0];
         end else begin
            value[i] = diff[i][16:0];
         end
      end
   end

   assign value_a = value[0];
   assign value_b = value[1];
   assign value_c = value[2];

endmodule

// ===== rtl/core/imu_serial_frame_parser.sv =====
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// Sync hunt, 8-bit sum check and field decode of inertial sensor frames.
// Throughput: one byte per cycle; a waiting result stalls only a frame's
// last byte. Latency: a result is valid the cycle after its last byte.
// Reset clears position, sum, seen bits, temperature, counters and registers.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser #(
   parameter int FRAME_BYTES = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [2:0]          rsp_frame_kind,
   output logic signed [16:0]  rsp_value_a,
   output logic signed [16:0]  rsp_value_b,
   output logic signed [16:0]  rsp_value_c,
   output logic signed [15:0]  rsp_value_d,
   output logic signed [15:0]  rsp_temperature_raw,
   output logic [4:0]          rsp_valid_bits,
   output logic [31:0]         rsp_good_frame_count,
   output logic [31:0]         rsp_angle_frame_count,
   output logic [31:0]         rsp_bad_sum_count,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [3:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import isfp_pkg::*;

   localparam int               POS_W    = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         store_ff [1:9];
   logic [4:0]         seen_ff, seen_in;
   logic [15:0]        temp_ff, temp_in;
   logic [31:0]        good_cnt_ff, good_cnt_in;
   logic [31:0]        angle_cnt_ff, angle_cnt_in;
   logic [31:0]        bad_cnt_ff, bad_cnt_in;

   logic [8:0]         sign_mask_ff;
   logic [15:0]        roll_off_ff, pitch_off_ff, yaw_off_ff;

   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   kind_type           kind_ff, kind_in;
   logic [16:0]        val_a_ff, val_b_ff, val_c_ff;
   logic [16:0]        val_a_in, val_b_in, val_c_in;
   logic [15:0]        val_d_ff, val_d_in;

   logic               accept, last_byte, sum_ok, known, good;
   kind_type           kind;
   decode_ctrl_type    ctrl;
   logic signed [16:0] dec_a, dec_b, dec_c;
   logic               csr_write;
   reg_index_type      csr_index;

   // handshakes
   assign req_ready = !rsp_valid_ff || rsp_ready || (pos_ff != LAST_POS);
   assign accept    = req_valid && req_ready;
   assign last_byte = accept && (pos_ff == LAST_POS);
   assign rsp_valid = rsp_valid_ff;

   // frame type decode
   always_comb begin
      known = 1'b1;
      unique case (store_ff[1])
         TYPE_ACCEL: kind = KIND_ACCEL;
         TYPE_GYRO:  kind = KIND_GYRO;
         TYPE_ANGLE: kind = KIND_ANGLE;
         TYPE_MAG:   kind = KIND_MAG;
         TYPE_QUAT:  kind = KIND_QUAT;
         default: begin
            kind  = KIND_ACCEL;
            known = 1'b0;
         end
      endcase
   end

   assign sum_ok         = (req_data_byte == sum_ff);
   assign good           = sum_ok && known;
   assign ctrl.kind      = kind;
   assign ctrl.sign_mask = sign_mask_ff;

   isfp_decode u_decode (
      .ctrl         (ctrl),
      .word_a       ({store_ff[3], store_ff[2]}),
      .word_b       ({store_ff[5], store_ff[4]}),
      .word_c       ({store_ff[7], store_ff[6]}),
      .roll_offset  (roll_off_ff),
      .pitch_offset (pitch_off_ff),
      .yaw_offset   (yaw_off_ff),
      .value_a      (dec_a),
      .value_b      (dec_b),
      .value_c      (dec_c)
   );

   // frame tracking and state update
   always_comb begin
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      seen_in      = seen_ff;
      temp_in      = temp_ff;
      good_cnt_in  = good_cnt_ff;
      angle_cnt_in = angle_cnt_ff;
      bad_cnt_in   = bad_cnt_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            if (req_data_byte == SYNC_BYTE) begin
               pos_in = POS_W'(1);
               sum_in = SYNC_BYTE;
            end
         end else if (pos_ff != LAST_POS) begin
            pos_in = pos_ff + POS_W'(1);
            sum_in = sum_ff + req_data_byte;
         end else begin
            pos_in = '0;
            if (!sum_ok) begin
               bad_cnt_in = bad_cnt_ff + 32'd1;
            end else if (known) begin
               seen_in     = seen_ff | (5'd1 << kind);
               good_cnt_in = good_cnt_ff + 32'd1;
               if (kind == KIND_ANGLE) begin
                  angle_cnt_in = angle_cnt_ff + 32'd1;
               end
               if (kind != KIND_QUAT) begin
                  temp_in = {store_ff[9], store_ff[8]};
               end
            end
         end
      end
   end

   // result payload
   always_comb begin
      if (!sum_ok) begin
         status_in = ST_BAD_SUM;
      end else if (known) begin
         status_in = ST_OK;
      end else begin
         status_in = ST_UNKNOWN;
      end
      kind_in  = good ? kind : KIND_ACCEL;
      val_a_in = good ? dec_a : 17'd0;
      val_b_in = good ? dec_b : 17'd0;
      val_c_in = good ? dec_c : 17'd0;
      val_d_in = (good && kind == KIND_QUAT) ? {store_ff[9], store_ff[8]} : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         seen_ff      <= '0;
         temp_ff      <= '0;
         good_cnt_ff  <= '0;
         angle_cnt_ff <= '0;
         bad_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         temp_ff      <= temp_in;
         good_cnt_ff  <= good_cnt_in;
         angle_cnt_ff <= angle_cnt_in;
         bad_cnt_ff   <= bad_cnt_in;
         if (last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= 9; i++) begin
         if (accept && pos_ff == POS_W'(i)) begin
            store_ff[i] <= req_data_byte;
         end
      end
      if (last_byte) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         val_a_ff  <= val_a_in;
         val_b_ff  <= val_b_in;
         val_c_ff  <= val_c_in;
         val_d_ff  <= val_d_in;
      end
   end

   assign rsp_status            = status_ff;
   assign rsp_frame_kind        = kind_ff;
   assign rsp_value_a           = val_a_ff;
   assign rsp_value_b           = val_b_ff;
   assign rsp_value_c           = val_c_ff;
   assign rsp_value_d           = val_d_ff;
   assign rsp_temperature_raw   = temp_ff;
   assign rsp_valid_bits        = seen_ff;
   assign rsp_good_frame_count  = good_cnt_ff;
   assign rsp_angle_frame_count = angle_cnt_ff;
   assign rsp_bad_sum_count     = bad_cnt_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_mask_ff <= '0;
         roll_off_ff  <= '0;
         pitch_off_ff <= '0;
         yaw_off_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SIGN_MASK:    sign_mask_ff <= csr_pwdata[8:0];
            REG_ROLL_OFFSET:  roll_off_ff  <= csr_pwdata[15:0];
            REG_PITCH_OFFSET: pitch_off_ff <= csr_pwdata[15:0];
            REG_YAW_OFFSET:   yaw_off_ff   <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SIGN_MASK:    csr_prdata = {23'd0, sign_mask_ff};
         REG_ROLL_OFFSET:  csr_prdata = {16'd0, roll_off_ff};
         REG_PITCH_OFFSET: csr_prdata = {16'd0, pitch_off_ff};
         REG_YAW_OFFSET:   csr_prdata = {16'd0, yaw_off_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // checks
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("byte position past frame end");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_byte))
      else $error("result raised without a last frame byte");

   a_bad_count: assert property (@(posedge clock) disable iff (reset)
      last_byte |=> ((bad_cnt_ff != $past(bad_cnt_ff)) == (rsp_status == ST_BAD_SUM)))
      else $error("checksum error count out of step with status");

   a_seen_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((seen_ff & $past(seen_ff)) == $past(seen_ff)))
      else $error("seen bit cleared");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for imu_serial_frame_parser. Bytes go in through the
// request channel; an in-bench predictor follows the sync hunt, checksum and
// field decode and queues the expected frame results. Each result is compared
// field by field. Covers every frame kind, bad sums, unknown types, sync bytes
// inside a frame, sign and offset settings, noise, and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import isfp_pkg::*;

   localparam int FRAME_BYTES  = 11;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASE_BYTES  = 180;
   localparam int FINAL_BYTES  = 200;
   localparam logic [39:0] KNOWN_TYPES = {TYPE_QUAT, TYPE_MAG, TYPE_ANGLE, TYPE_GYRO,
                                          TYPE_ACCEL};

   typedef struct {
      status_type         status;
      kind_type           kind;
      logic signed [16:0] value_a;
      logic signed [16:0] value_b;
      logic signed [16:0] value_c;
      logic signed [15:0] value_d;
      logic signed [15:0] temperature;
      logic [4:0]         seen;
      logic [31:0]        good_count;
      logic [31:0]        angle_count;
      logic [31:0]        bad_count;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [7:0]          req_data_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic [2:0]          rsp_frame_kind;
   logic signed [16:0]  rsp_value_a;
   logic signed [16:0]  rsp_value_b;
   logic signed [16:0]  rsp_value_c;
   logic signed [15:0]  rsp_value_d;
   logic signed [15:0]  rsp_temperature_raw;
   logic [4:0]          rsp_valid_bits;
   logic [31:0]         rsp_good_frame_count;
   logic [31:0]         rsp_angle_frame_count;
   logic [31:0]         rsp_bad_sum_count;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [3:0]          csr_paddr = 4'h0;
   logic [31:0]         csr_pwdata = 32'h0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // predictor state
   logic [7:0]         frame_buf [FRAME_BYTES];
   int                 frame_pos = 0;
   logic [7:0]         frame_sum = 8'h00;
   logic [4:0]         seen_kinds = 5'h00;
   logic [15:0]        temp_hold = 16'h0000;
   logic [31:0]        decoded_total = 32'h0;
   logic [31:0]        angle_total = 32'h0;
   logic [31:0]        bad_sum_total = 32'h0;
   logic [8:0]         cfg_sign_mask = 9'h000;
   logic signed [15:0] cfg_offset [3] = '{16'sd0, 16'sd0, 16'sd0};

   frame_result_type expected_frames [$];
   int               mismatches = 0;
   int               bytes_sent = 0;
   logic             idle_en = 1'b1;
   logic             hold_request = 1'b0;
   int               hold_left = 0;
   int               stall_left = 0;

   imu_serial_frame_parser #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_frame_kind        (rsp_frame_kind),
      .rsp_value_a           (rsp_value_a),
      .rsp_value_b           (rsp_value_b),
      .rsp_value_c           (rsp_value_c),
      .rsp_value_d           (rsp_value_d),
      .rsp_temperature_raw   (rsp_temperature_raw),
      .rsp_valid_bits        (rsp_valid_bits),
      .rsp_good_frame_count  (rsp_good_frame_count),
      .rsp_angle_frame_count (rsp_angle_frame_count),
      .rsp_bad_sum_count     (rsp_bad_sum_count),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void parse_byte(input logic [7:0] b);
      frame_result_type r;
      int               axis [4];
      int               base;
      logic             known;
      if (frame_pos == 0) begin
         if (b == SYNC_BYTE) begin
            frame_buf[0] = b;
            frame_sum = b;
            frame_pos = 1;
         end
         return;
      end
      frame_buf[frame_pos] = b;
      if (frame_pos < FRAME_BYTES - 1) begin
         frame_sum = frame_sum + b;
         frame_pos++;
         return;
      end
      frame_pos = 0;
      r.status = ST_OK;
      r.kind = KIND_ACCEL;
      axis = '{0, 0, 0, 0};
      known = 1'b1;
      if (b != frame_sum) begin
         r.status = ST_BAD_SUM;
         bad_sum_total++;
      end else begin
         case (frame_buf[1])
            TYPE_ACCEL: r.kind = KIND_ACCEL;
            TYPE_GYRO:  r.kind = KIND_GYRO;
            TYPE_ANGLE: r.kind = KIND_ANGLE;
            TYPE_MAG:   r.kind = KIND_MAG;
            TYPE_QUAT:  r.kind = KIND_QUAT;
            default:    known = 1'b0;
         endcase
         if (!known) begin
            r.status = ST_UNKNOWN;
            r.kind = KIND_ACCEL;
         end else begin
            for (int i = 0; i < 4; i++) begin
               axis[i] = int'($signed({frame_buf[3 + 2 * i], frame_buf[2 + 2 * i]}));
            end
            if (r.kind != KIND_QUAT) begin
               axis[3] = 0;
               base = (r.kind == KIND_ACCEL) ? 0 : (r.kind == KIND_GYRO) ? 3 : 6;
               if (r.kind != KIND_MAG) begin
                  for (int i = 0; i < 3; i++) begin
                     if (cfg_sign_mask[base + i]) axis[i] = -axis[i];
                     if (r.kind == KIND_ANGLE) begin
                        axis[i] = axis[i] - cfg_offset[i];
                        if (axis[i] > 65535) axis[i] = 65535;
                        else if (axis[i] < -65536) axis[i] = -65536;
                     end
                  end
               end
               temp_hold = {frame_buf[9], frame_buf[8]};
            end
            seen_kinds[r.kind] = 1'b1;
            if (r.kind == KIND_ANGLE) angle_total++;
            decoded_total++;
         end
      end
      r.value_a = axis[0][16:0];
      r.value_b = axis[1][16:0];
      r.value_c = axis[2][16:0];
      r.value_d = axis[3][15:0];
      r.temperature = temp_hold;
      r.seen = seen_kinds;
      r.good_count = decoded_total;
      r.angle_count = angle_total;
      r.bad_count = bad_sum_total;
      expected_frames.push_back(r);
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic signed [63:0] want,
                                       input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (idle_en && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      parse_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] kind_byte, input logic [63:0] payload,
                             input logic [7:0] sum_flip);
      logic [7:0] frame_bytes [FRAME_BYTES];
      logic [7:0] sum;
      frame_bytes[0] = SYNC_BYTE;
      frame_bytes[1] = kind_byte;
      for (int k = 0; k < 8; k++) frame_bytes[2 + k] = payload[8 * k +: 8];
      sum = 8'h00;
      for (int k = 0; k < FRAME_BYTES - 1; k++) sum = sum + frame_bytes[k];
      frame_bytes[FRAME_BYTES - 1] = sum ^ sum_flip;
      for (int k = 0; k < FRAME_BYTES; k++) send_byte(frame_bytes[k]);
   endtask

   task automatic random_frame();
      logic [7:0] kind_byte;
      logic [7:0] flip;
      kind_byte = KNOWN_TYPES[8 * $urandom_range(0, 4) +: 8];
      if ($urandom_range(0, 19) == 0) kind_byte = 8'($urandom);
      flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end
      send_frame(kind_byte, {pick_word(), pick_word(), pick_word(), pick_word()}, flip);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      // close any open frame so the new setting applies from a frame boundary
      while (frame_pos != 0) send_byte(8'($urandom));
      settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_SIGN_MASK:    cfg_sign_mask = value[8:0];
         REG_ROLL_OFFSET:  cfg_offset[0] = value[15:0];
         REG_PITCH_OFFSET: cfg_offset[1] = value[15:0];
         REG_YAW_OFFSET:   cfg_offset[2] = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [8:0] mask, input int roll, input int pitch,
                                input int yaw);
      write_reg(REG_SIGN_MASK, 32'(mask));
      write_reg(REG_ROLL_OFFSET, 32'(roll));
      write_reg(REG_PITCH_OFFSET, 32'(pitch));
      write_reg(REG_YAW_OFFSET, 32'(yaw));
   endtask

   task automatic test_frame_kinds();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hAA);
      send_frame(TYPE_ACCEL, {16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF}, 8'h00);
      send_frame(TYPE_GYRO,  {16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000}, 8'h00);
      send_frame(TYPE_ANGLE, {16'h8000, 16'h0001, 16'h7FFF, 16'h8000}, 8'h00);
      send_frame(TYPE_MAG,   {16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF}, 8'h00);
      send_frame(TYPE_QUAT,  {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000}, 8'h00);
      send_frame(TYPE_GYRO,  64'h0123_4567_89AB_CDEF, 8'h01);
      send_frame(8'h50,      64'hFEDC_BA98_7654_3210, 8'h00);
      send_frame(8'hFF,      64'h0, 8'h00);
      send_frame(TYPE_ACCEL, 64'h5555_5555_5555_5555, 8'h00);
      settle();
   endtask

   task automatic test_sign_and_offset();
      apply_setting(9'h1FF, -32768, 32767, 0);
      send_frame(TYPE_ANGLE, {16'h0000, 16'h1234, 16'h7FFF, 16'h8000}, 8'h00);
      send_frame(TYPE_ANGLE, {16'h0000, 16'h8000, 16'h8000, 16'h7FFF}, 8'h00);
      send_frame(TYPE_ACCEL, {16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF}, 8'h00);
      send_frame(TYPE_GYRO,  {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF}, 8'h00);
      apply_setting(9'h0A5, 32767, -32768, -1);
      send_frame(TYPE_ANGLE, {16'h0000, 16'h8000, 16'h7FFF, 16'h8000}, 8'h00);
      send_frame(TYPE_ACCEL, {16'h0000, 16'h8000, 16'h8000, 16'h8000}, 8'h00);
      settle();
   endtask

   task automatic test_random_traffic();
      int start;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0:       apply_setting(9'h000, 0, 0, 0);
            1:       apply_setting(9'h1FF, -32768, -32768, -32768);
            2:       apply_setting(9'h000, 32767, 32767, 32767);
            default: apply_setting(9'($urandom_range(0, 511)),
                                   int'($urandom_range(0, 65535)) - 32768,
                                   int'($urandom_range(0, 65535)) - 32768,
                                   int'($urandom_range(0, 65535)) - 32768);
         endcase
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) random_frame();
      end
      settle();
   endtask

   task automatic test_backpressure();
      idle_en = 1'b0;
      hold_request = 1'b1;
      repeat (12) random_frame();
      settle();
      idle_en = 1'b1;
   endtask

   task automatic test_steady_stream();
      int start;
      idle_en = 1'b0;
      apply_setting(9'($urandom_range(0, 511)), int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768,
                    int'($urandom_range(0, 65535)) - 32768);
      start = bytes_sent;
      while (bytes_sent - start < FINAL_BYTES) random_frame();
      settle();
   endtask

   always @(posedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected frame result, status %0d", rsp_status);
            mismatches++;
         end else begin
            want = expected_frames.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("frame_kind", want.kind, rsp_frame_kind);
            check_field("value_a", want.value_a, rsp_value_a);
            check_field("value_b", want.value_b, rsp_value_b);
            check_field("value_c", want.value_c, rsp_value_c);
            check_field("value_d", want.value_d, rsp_value_d);
            check_field("temperature_raw", want.temperature, rsp_temperature_raw);
            check_field("valid_bits", want.seen, rsp_valid_bits);
            check_field("good_frame_count", want.good_count, rsp_good_frame_count);
            check_field("angle_frame_count", want.angle_count, rsp_angle_frame_count);
            check_field("bad_sum_count", want.bad_count, rsp_bad_sum_count);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_frame_kinds();
      test_sign_and_offset();
      test_random_traffic();
      test_backpressure();
      test_steady_stream();
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
